>>> rtl/core/text_mode_console_writer_top_defines.svh
// ----------------------------------------------------------------------------
// Text mode console writer: assertion macros
// Shared property shorthands for the console writer's checks.
// ----------------------------------------------------------------------------
`ifndef TEXT_MODE_CONSOLE_WRITER_TOP_DEFINES_SVH
`define TEXT_MODE_CONSOLE_WRITER_TOP_DEFINES_SVH

// same-cycle implication under reset
`define TMCW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under reset
`define TMCW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/tmcw_pkg.sv
// ----------------------------------------------------------------------------
// tmcw_pkg
// Types, codes and helpers shared by the text mode console writer.
// ----------------------------------------------------------------------------
package tmcw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [3:0] FORE_RESET   = 4'hF;
    localparam logic [3:0] BACK_RESET   = 4'h0;

    localparam logic CFG_FORE = 1'b0;
    localparam logic CFG_BACK = 1'b1;

    typedef enum logic [2:0] {
        ACT_PUT    = 3'd0,
        ACT_SET    = 3'd1,
        ACT_MOVE   = 3'd2,
        ACT_SCROLL = 3'd3,
        ACT_CLEAR  = 3'd4,
        ACT_READ   = 3'd5
    } action_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_SWEEP,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        SWEEP_CLEAR,
        SWEEP_UP,
        SWEEP_DOWN
    } sweep_mode_t;

    typedef struct packed {
        logic        start;
        sweep_mode_t mode;
    } sweep_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } sweep_stat_t;

    // clamp a signed value into 0..hi
    function automatic logic [9:0] sat_range(input logic signed [9:0] v,
                                             input logic [9:0] hi);
        logic [9:0] r;
        if (v < 0)
        begin
            r = '0;
        end
        else if (v > $signed(hi))
        begin
            r = hi;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

>>> rtl/core/tmcw_screen_ram.sv
// ----------------------------------------------------------------------------
// tmcw_screen_ram
// Screen cell store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tmcw_screen_ram #(
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = 11
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [15:0]       wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [15:0]       rdata
);

    logic [15:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // hold read data when no read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/core/tmcw_sweep.sv
// ----------------------------------------------------------------------------
// tmcw_sweep
// Whole-screen pass: copies cells for scrolling and fills vacated or cleared
// cells, one cell per cycle through one shared address adder.
// ----------------------------------------------------------------------------
module tmcw_sweep #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    parameter int ADDR_W  = 11,
    parameter int NL_W    = 5
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tmcw_pkg::sweep_ctl_t ctl,
    input  logic [NL_W-1:0]      lines,
    input  logic [15:0]          fill,
    input  logic [15:0]          rdata,
    output tmcw_pkg::sweep_stat_t stat,
    output logic                 we,
    output logic [ADDR_W-1:0]    waddr,
    output logic [15:0]          wdata,
    output logic                 re,
    output logic [ADDR_W-1:0]    raddr
);
    import tmcw_pkg::*;

    localparam int TOTAL = ROWS * COLUMNS;

    logic                active_reg, active_next;
    logic                pend_reg, pend_next;
    sweep_mode_t         mode_reg, mode_next;
    logic [ADDR_W-1:0]   idx_reg, idx_next;
    logic [ADDR_W:0]     off_reg, off_next;
    logic [ADDR_W:0]     lim_reg, lim_next;
    logic [15:0]         fill_reg, fill_next;
    logic [ADDR_W-1:0]   pend_addr_reg, pend_addr_next;
    logic                pend_copy_reg, pend_copy_next;

    logic [ADDR_W-1:0]   dst;
    logic [ADDR_W:0]     src_wide;
    logic [ADDR_W:0]     start_off;
    logic                copy;

    // shared address unit: destination, source and copy decision
    always_comb
    begin
        if (mode_reg == SWEEP_DOWN)
        begin
            dst = ADDR_W'(TOTAL - 1) - idx_reg;
        end
        else
        begin
            dst = idx_reg;
        end
        src_wide = {1'b0, dst} + ((mode_reg == SWEEP_DOWN) ? -off_reg : off_reg);
        case (mode_reg)
            SWEEP_UP:   copy = ({1'b0, idx_reg} < lim_reg);
            SWEEP_DOWN: copy = ({1'b0, dst} >= off_reg);
            default:    copy = 1'b0;
        endcase
        copy = copy && active_reg;
    end

    assign start_off = (ADDR_W + 1)'(lines * COLUMNS);

    always_comb
    begin
        active_next    = active_reg;
        pend_next      = active_reg;
        mode_next      = mode_reg;
        idx_next       = idx_reg;
        off_next       = off_reg;
        lim_next       = lim_reg;
        fill_next      = fill_reg;
        pend_addr_next = dst;
        pend_copy_next = copy;
        if (active_reg)
        begin
            idx_next = idx_reg + 1'b1;
            if (idx_reg == ADDR_W'(TOTAL - 1))
            begin
                active_next = 1'b0;
            end
        end
        if (ctl.start)
        begin
            active_next = 1'b1;
            idx_next    = '0;
            mode_next   = ctl.mode;
            off_next    = start_off;
            lim_next    = (ADDR_W + 1)'(TOTAL) - start_off;
            fill_next   = (ctl.mode == SWEEP_CLEAR) ? 16'h0000 : fill;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            pend_reg   <= 1'b0;
            mode_reg   <= SWEEP_CLEAR;
            idx_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            pend_reg   <= pend_next;
            mode_reg   <= mode_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        off_reg       <= off_next;
        lim_reg       <= lim_next;
        fill_reg      <= fill_next;
        pend_addr_reg <= pend_addr_next;
        pend_copy_reg <= pend_copy_next;
    end

    // write lands in the cycle after the read it depends on
    assign re        = copy;
    assign raddr     = src_wide[ADDR_W-1:0];
    assign we        = pend_reg;
    assign waddr     = pend_addr_reg;
    assign wdata     = pend_copy_reg ? rdata : fill_reg;
    assign stat.busy = active_reg || pend_reg;
    assign stat.done = pend_reg && !active_reg;

endmodule

>>> rtl/core/text_mode_console_writer_top.sv
// ----------------------------------------------------------------------------
// text_mode_console_writer_top
// Text console: screen cell store, cursor, and put/set/move/scroll/clear/read.
// ----------------------------------------------------------------------------
// An item is taken only in the idle state and yields one result item. Put
// character (no wrap at the bottom row), set cursor, move cursor, read cell and
// unused codes run no screen pass; scroll by a nonzero count, clear, and a
// newline or wrap on the bottom row run the pass over the screen memory, one
// cell per cycle, whose single write port moves or fills every cell. After
// reset the memory is cleared by the same pass before item_ready first rises;
// configuration writes are taken at any time.
`include "text_mode_console_writer_top_defines.svh"

module text_mode_console_writer_top #(
    parameter int COLUMNS = tmcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tmcw_pkg::ROWS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic              cfg_index,
    input  logic [3:0]        cfg_data,
    input  logic              item_valid,
    output logic              item_ready,
    input  logic [2:0]        action,
    input  logic [7:0]        char_code,
    input  logic signed [5:0] row_arg,
    input  logic signed [7:0] col_arg,
    input  logic signed [5:0] scroll_lines,
    output logic              result_valid,
    input  logic              result_ready,
    output logic [15:0]       cell_data,
    output logic [4:0]        cursor_row,
    output logic [6:0]        cursor_col
);
    import tmcw_pkg::*;

    localparam int TOTAL  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(TOTAL);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int NL_W   = $clog2(ROWS + 1);

    state_t            state_reg, state_next;
    logic              init_reg, init_next;
    action_t           act_reg;
    logic [7:0]        char_reg;
    logic signed [5:0] row_arg_reg;
    logic signed [7:0] col_arg_reg;
    logic signed [5:0] scroll_reg;
    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [3:0]        fore_reg, back_reg;
    logic              res_valid_reg, res_valid_next;
    logic [15:0]       res_cell_reg;
    logic [4:0]        res_row_reg;
    logic [6:0]        res_col_reg;

    // decode results
    logic              go_sweep;
    sweep_mode_t       dec_mode;
    logic [NL_W-1:0]   dec_lines;
    logic signed [9:0] ra10, ca10, sl10, mv_row, mv_col, room10;
    logic [9:0]        mag10, clamp10;
    logic [NL_W-1:0]   nlines;
    logic [ROW_W-1:0]  sat_row;
    logic [COL_W-1:0]  sat_col;
    logic [ROW_W-1:0]  sel_row;
    logic [COL_W-1:0]  sel_col;
    logic [ADDR_W-1:0] cell_addr;
    logic [7:0]        attr;
    logic              put_we, rd_re, load;

    // sweep and ram wiring
    sweep_ctl_t        sweep_ctl;
    sweep_stat_t       sweep_stat;
    logic              sw_we, sw_re;
    logic [ADDR_W-1:0] sw_waddr, sw_raddr;
    logic [15:0]       sw_wdata;
    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [15:0]       ram_wdata, ram_rdata;

    assign attr = {back_reg, fore_reg};

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fore_reg <= FORE_RESET;
            back_reg <= BACK_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_FORE: fore_reg <= cfg_data;
                CFG_BACK: back_reg <= cfg_data;
                default:  fore_reg <= fore_reg;
            endcase
        end
    end

    // ---------------- operand arithmetic ----------------
    always_comb
    begin
        ra10    = 10'(row_arg_reg);
        ca10    = 10'(col_arg_reg);
        sl10    = 10'(scroll_reg);
        mv_row  = 10'(row_arg_reg) + 10'(cur_row_reg);
        mv_col  = 10'(col_arg_reg) + 10'(cur_col_reg);
        sat_row = ROW_W'(sat_range(ra10, 10'(ROWS - 1)));
        sat_col = COL_W'(sat_range(ca10, 10'(COLUMNS - 1)));
        mag10   = (sl10 < 0) ? 10'(-sl10) : 10'(sl10);
        clamp10 = (mag10 > 10'(ROWS)) ? 10'(ROWS) : mag10;
        nlines  = NL_W'(clamp10);
        room10  = 10'(ROWS - 1) - 10'(cur_row_reg);
        // one address unit for both the cursor cell and the read cell
        if (act_reg == ACT_READ)
        begin
            sel_row = sat_row;
            sel_col = sat_col;
        end
        else
        begin
            sel_row = cur_row_reg;
            sel_col = cur_col_reg;
        end
        cell_addr = ADDR_W'(sel_row * COLUMNS) + ADDR_W'(sel_col);
    end

    // ---------------- cursor and action decode ----------------
    always_comb
    begin
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        go_sweep     = 1'b0;
        dec_mode     = SWEEP_UP;
        dec_lines    = NL_W'(1);
        unique case (act_reg)
            ACT_PUT:
            begin
                if ((char_reg == NEWLINE_CODE) || (cur_col_reg == COL_W'(COLUMNS - 1)))
                begin
                    cur_col_next = '0;
                    // bottom row: scroll one line, row stays
                    if (cur_row_reg == ROW_W'(ROWS - 1))
                    begin
                        go_sweep = 1'b1;
                    end
                    else
                    begin
                        cur_row_next = cur_row_reg + 1'b1;
                    end
                end
                else
                begin
                    cur_col_next = cur_col_reg + 1'b1;
                end
            end
            ACT_SET:
            begin
                cur_row_next = sat_row;
                cur_col_next = sat_col;
            end
            ACT_MOVE:
            begin
                cur_row_next = ROW_W'(sat_range(mv_row, 10'(ROWS - 1)));
                cur_col_next = COL_W'(sat_range(mv_col, 10'(COLUMNS - 1)));
            end
            ACT_SCROLL:
            begin
                dec_lines = nlines;
                if (sl10 > 0)
                begin
                    go_sweep = 1'b1;
                    dec_mode = SWEEP_UP;
                    if (clamp10 > 10'(cur_row_reg))
                    begin
                        cur_row_next = '0;
                        cur_col_next = '0;
                    end
                    else
                    begin
                        cur_row_next = cur_row_reg - ROW_W'(nlines);
                    end
                end
                else if (sl10 < 0)
                begin
                    go_sweep = 1'b1;
                    dec_mode = SWEEP_DOWN;
                    if ($signed(clamp10) > room10)
                    begin
                        cur_row_next = ROW_W'(ROWS - 1);
                        cur_col_next = COL_W'(COLUMNS - 1);
                    end
                    else
                    begin
                        cur_row_next = cur_row_reg + ROW_W'(nlines);
                    end
                end
            end
            ACT_CLEAR:
            begin
                go_sweep = 1'b1;
                dec_mode = SWEEP_CLEAR;
            end
            default:
            begin
                cur_row_next = cur_row_reg;
            end
        endcase
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        init_next  = init_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                state_next = ST_SWEEP;
            end
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next = go_sweep ? ST_SWEEP : ST_DONE;
            end
            ST_SWEEP:
            begin
                if (sweep_stat.done)
                begin
                    init_next  = 1'b0;
                    state_next = init_reg ? ST_IDLE : ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!res_valid_reg || result_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_ready      = (state_reg == ST_IDLE);
        sweep_ctl.start = (state_reg == ST_INIT) || ((state_reg == ST_DECODE) && go_sweep);
        sweep_ctl.mode  = (state_reg == ST_INIT) ? SWEEP_CLEAR : dec_mode;
        put_we          = (state_reg == ST_DECODE) && (act_reg == ACT_PUT)
                          && (char_reg != NEWLINE_CODE);
        rd_re           = (state_reg == ST_DECODE) && (act_reg == ACT_READ);
        load            = (state_reg == ST_DONE) && (!res_valid_reg || result_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_INIT;
            init_reg    <= 1'b1;
            cur_row_reg <= '0;
            cur_col_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            init_reg  <= init_next;
            if (state_reg == ST_DECODE)
            begin
                cur_row_reg <= cur_row_next;
                cur_col_reg <= cur_col_next;
            end
        end
    end

    // capture the item
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            act_reg     <= action_t'(action);
            char_reg    <= char_code;
            row_arg_reg <= row_arg;
            col_arg_reg <= col_arg;
            scroll_reg  <= scroll_lines;
        end
    end

    // ---------------- result register ----------------
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (load)
        begin
            res_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_cell_reg <= (act_reg == ACT_READ) ? ram_rdata : 16'h0000;
            res_row_reg  <= 5'(cur_row_reg);
            res_col_reg  <= 7'(cur_col_reg);
        end
    end

    assign result_valid = res_valid_reg;
    assign cell_data    = res_cell_reg;
    assign cursor_row   = res_row_reg;
    assign cursor_col   = res_col_reg;

    // ---------------- memory ports ----------------
    always_comb
    begin
        ram_we    = sw_we || put_we;
        ram_waddr = sw_we ? sw_waddr : cell_addr;
        ram_wdata = sw_we ? sw_wdata : {attr, char_reg};
        ram_re    = sw_re || rd_re;
        ram_raddr = sw_re ? sw_raddr : cell_addr;
    end

    tmcw_sweep #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .ADDR_W  (ADDR_W),
        .NL_W    (NL_W)
    ) u_sweep (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (sweep_ctl),
        .lines (dec_lines),
        .fill  ({attr, 8'h00}),
        .rdata (ram_rdata),
        .stat  (sweep_stat),
        .we    (sw_we),
        .waddr (sw_waddr),
        .wdata (sw_wdata),
        .re    (sw_re),
        .raddr (sw_raddr)
    );

    tmcw_screen_ram #(
        .DEPTH  (TOTAL),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ---------------- checks ----------------
    `TMCW_ASSERT_NOW(a_idle_no_sweep, clk, rst_n, item_ready, !sweep_stat.busy,
        "item taken while a screen pass is running")
    `TMCW_ASSERT_NOW(a_done_in_sweep, clk, rst_n, sweep_stat.done, state_reg == ST_SWEEP,
        "screen pass finished outside the sweep state")
    `TMCW_ASSERT_NOW(a_no_write_clash, clk, rst_n, put_we, !sw_we,
        "character write collides with a screen pass write")
    `TMCW_ASSERT_NOW(a_cursor_bounds, clk, rst_n, 1'b1,
        (32'(cur_row_reg) <= ROWS - 1) && (32'(cur_col_reg) <= COLUMNS - 1),
        "cursor outside the screen")
    `TMCW_ASSERT_NEXT(a_accept_decode, clk, rst_n, item_valid && item_ready,
        state_reg == ST_DECODE && !result_valid || state_reg == ST_DECODE,
        "accepted item not decoded next cycle")

endmodule

>>> tb/tb_text_mode_console_writer_top.sv
// ----------------------------------------------------------------------------
// Console writer testbench
// Drives put/set/move/scroll/clear/read items through the valid/ready input,
// predicts most results with a shadow screen and cursor kept here, and checks
// each result item field by field. A directed table comes first, then five
// random phases, each under its own color setting, with random idling on both
// sides, one long receiver hold-off and one stretch with no idling at all.
// ----------------------------------------------------------------------------
module tb_text_mode_console_writer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tmcw_pkg::*;

    localparam int COLS  = COLUMNS_DEF;
    localparam int ROWS  = ROWS_DEF;
    localparam int CELLS = ROWS * COLS;

    localparam logic [2:0] ACT_SPARE6 = 3'd6;
    localparam logic [2:0] ACT_SPARE7 = 3'd7;

    localparam int PHASES          = 5;
    localparam int ITEMS_PER_PHASE = 110;
    localparam int HOLD_CYCLES     = 400;
    localparam int TAIL_CYCLES     = 12;
    // every item at full-screen latency plus idling, taken several times over
    localparam int CYCLE_LIMIT     = 5000000;
    localparam int DIRECTED_ROWS   = 26;

    typedef struct {
        logic [2:0]        act;
        logic [7:0]        chr;
        logic signed [5:0] ra;
        logic signed [7:0] ca;
        logic signed [5:0] sl;
        bit                typed;
        logic [15:0]       cell_val;
        logic [4:0]        row;
        logic [6:0]        col;
    } console_step_t;

    typedef struct {
        logic [15:0] cell_val;
        logic [4:0]  row;
        logic [6:0]  col;
    } console_report_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_wr_en;
    logic              cfg_index;
    logic [3:0]        cfg_data;
    logic              item_valid;
    logic              item_ready;
    logic [2:0]        action;
    logic [7:0]        char_code;
    logic signed [5:0] row_arg;
    logic signed [7:0] col_arg;
    logic signed [5:0] scroll_lines;
    logic              result_valid;
    logic              result_ready = 1'b0;
    logic [15:0]       cell_data;
    logic [4:0]        cursor_row;
    logic [6:0]        cursor_col;

    // shadow of the block's screen, cursor and colors
    logic [15:0] shadow_cells [CELLS];
    int          shadow_row;
    int          shadow_col;
    logic [3:0]  shadow_fore;
    logic [3:0]  shadow_back;

    console_report_t report_q [$];

    int  fail_count      = 0;
    int  reports_checked = 0;
    int  cycle_count     = 0;
    int  act_count [8]   = '{default: 0};
    int  hold_count      = 0;
    logic hold_req       = 1'b0;
    logic steady         = 1'b0;

    console_step_t plan [DIRECTED_ROWS] = '{
        '{ACT_READ,   8'h00, 6'sd0,  8'sd0,   6'sd0,  1'b1, 16'h0000, 5'd0,  7'd0},
        '{ACT_PUT,    8'h41, 6'sd0,  8'sd0,   6'sd0,  1'b0, 16'h0000, 5'd0,  7'd0},
        '{ACT_PUT,    8'hFF, 6'sd0,  8'sd0,   6'sd0,  1'b0, 16'h0000, 5'd0,  7'd0},
        '{ACT_PUT,    NEWLINE_CODE, 6'sd0, 8'sd0, 6'sd0, 1'b0, 16'h0000, 5'd0, 7'd0},
        '{ACT_SET,    8'h00, 6'sd31, 8'sd127, 6'sd0,  1'b1, 16'h0000, 5'd24, 7'd79},
        // wrap on the bottom row scrolls the screen
        '{ACT_PUT,    8'h5A, 6'sd0,  8'sd0,   6'sd0,  1'b0, 16'h0000, 5'd0,  7'd0},
        '{ACT_READ,   8'h00, 6'sd23, 8'sd79,  6'sd0,  1'b0, 16'h0000, 5'd0,  7'd0},
        '{ACT_SET,    8'h00, 6'sh20, 8'sh80,  6'sd0,  1'b1, 16'h0000, 5'd0,  7'd0},
        '{ACT_MOVE,   8'h00, 6'sd31, 8'sd127, 6'sd0,  1'b1, 16'h0000, 5'd24, 7'd79},
        '{ACT_MOVE,   8'h00, 6'sh20, 8'sh80,  6'sd0,  1'b1, 16'h0000, 5'd0,  7'd0},
        '{ACT_MOVE,   8'h00, 6'sd3,  8'sd5,   6'sd0,  1'b0, 16'h0000, 5'd0,  7'd0},
        '{ACT_SCROLL, 8'h00, 6'sd0,  8'sd0,   6'sd0,  1'b0, 16'h0000, 5'd0,  7'd0},
        '{ACT_SCROLL, 8'h00, 6'sd0,  8'sd0,   6'sd1,  1'b0, 16'h0000, 5'd0,  7'd0},
        // scroll past the top row resets the column
        '{ACT_SCROLL, 8'h00, 6'sd0,  8'sd0,   6'sd3,  1'b0, 16'h0000, 5'd0,  7'd0},
        '{ACT_SET,    8'h00, 6'sd24, 8'sd10,  6'sd0,  1'b0, 16'h0000, 5'd0,  7'd0},
        // scroll down from the bottom row parks the cursor at the last column
        '{ACT_SCROLL, 8'h00, 6'sd0,  8'sd0,   -6'sd1, 1'b0, 16'h0000, 5'd0,  7'd0},
        '{ACT_SCROLL, 8'h00, 6'sd0,  8'sd0,   6'sd31, 1'b0, 16'h0000, 5'd0,  7'd0},
        '{ACT_SCROLL, 8'h00, 6'sd0,  8'sd0,   6'sh20, 1'b0, 16'h0000, 5'd0,  7'd0},
        '{ACT_READ,   8'h00, 6'sh20, 8'sh80,  6'sd0,  1'b0, 16'h0000, 5'd0,  7'd0},
        '{ACT_READ,   8'h00, 6'sd31, 8'sd127, 6'sd0,  1'b0, 16'h0000, 5'd0,  7'd0},
        '{ACT_SPARE6, 8'hFF, 6'sd31, 8'sd127, 6'sd31, 1'b0, 16'h0000, 5'd0,  7'd0},
        '{ACT_SPARE7, 8'h00, 6'sh20, 8'sh80,  6'sh20, 1'b0, 16'h0000, 5'd0,  7'd0},
        '{ACT_SET,    8'h00, 6'sd24, 8'sd0,   6'sd0,  1'b0, 16'h0000, 5'd0,  7'd0},
        '{ACT_PUT,    NEWLINE_CODE, 6'sd0, 8'sd0, 6'sd0, 1'b0, 16'h0000, 5'd0, 7'd0},
        '{ACT_CLEAR,  8'h00, 6'sd0,  8'sd0,   6'sd0,  1'b0, 16'h0000, 5'd0,  7'd0},
        '{ACT_READ,   8'h00, 6'sd24, 8'sd79,  6'sd0,  1'b1, 16'h0000, 5'd24, 7'd0}
    };

    text_mode_console_writer_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .action       (action),
        .char_code    (char_code),
        .row_arg      (row_arg),
        .col_arg      (col_arg),
        .scroll_lines (scroll_lines),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cell_data    (cell_data),
        .cursor_row   (cursor_row),
        .cursor_col   (cursor_col)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int clamp(input int v, input int hi);
        if (v < 0)
        begin
            return 0;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    // positive lines move text up, negative down; vacated rows get blanks
    function automatic void shift_screen(input int lines);
        logic [15:0] blank;
        int          n;
        blank = {shadow_back, shadow_fore, 8'h00};
        n = clamp(lines + ROWS, 2 * ROWS) - ROWS;
        if (n > 0)
        begin
            for (int k = 0; k < CELLS; k++)
            begin
                if (k < CELLS - n * COLS)
                    shadow_cells[k] = shadow_cells[k + n * COLS];
                else
                    shadow_cells[k] = blank;
            end
            if (n > shadow_row)
            begin
                shadow_row = 0;
                shadow_col = 0;
            end
            else
            begin
                shadow_row -= n;
            end
        end
        else if (n < 0)
        begin
            n = -n;
            for (int k = CELLS - 1; k >= 0; k--)
            begin
                if (k >= n * COLS)
                    shadow_cells[k] = shadow_cells[k - n * COLS];
                else
                    shadow_cells[k] = blank;
            end
            if (n > ROWS - 1 - shadow_row)
            begin
                shadow_row = ROWS - 1;
                shadow_col = COLS - 1;
            end
            else
            begin
                shadow_row += n;
            end
        end
    endfunction

    function automatic void line_feed();
        shadow_col = 0;
        if (shadow_row >= ROWS - 1)
            shift_screen(1);
        shadow_row++;
    endfunction

    function automatic console_report_t console_apply(input console_step_t s);
        console_report_t r;
        r.cell_val = 16'h0000;
        case (s.act)
            ACT_PUT:
            begin
                if (s.chr == NEWLINE_CODE)
                begin
                    line_feed();
                end
                else
                begin
                    shadow_cells[shadow_row * COLS + shadow_col] =
                        {shadow_back, shadow_fore, s.chr};
                    shadow_col++;
                    if (shadow_col >= COLS)
                        line_feed();
                end
            end
            ACT_SET:
            begin
                shadow_row = clamp(int'(s.ra), ROWS - 1);
                shadow_col = clamp(int'(s.ca), COLS - 1);
            end
            ACT_MOVE:
            begin
                shadow_row = clamp(shadow_row + int'(s.ra), ROWS - 1);
                shadow_col = clamp(shadow_col + int'(s.ca), COLS - 1);
            end
            ACT_SCROLL:
            begin
                shift_screen(int'(s.sl));
            end
            ACT_CLEAR:
            begin
                foreach (shadow_cells[k])
                    shadow_cells[k] = 16'h0000;
            end
            ACT_READ:
            begin
                r.cell_val = shadow_cells[clamp(int'(s.ra), ROWS - 1) * COLS
                                          + clamp(int'(s.ca), COLS - 1)];
            end
            default:
            begin
            end
        endcase
        r.row = 5'(shadow_row);
        r.col = 7'(shadow_col);
        return r;
    endfunction

    // present one item, hold it until taken, then queue its expected result
    task automatic offer(input console_step_t s);
        console_report_t r;
        while (!steady && $urandom_range(99) < 26)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid   <= 1'b1;
        action       <= s.act;
        char_code    <= s.chr;
        row_arg      <= s.ra;
        col_arg      <= s.ca;
        scroll_lines <= s.sl;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        r = console_apply(s);
        if (s.typed)
            r = '{s.cell_val, s.row, s.col};
        report_q.push_back(r);
        act_count[s.act]++;
        @(negedge clk);
    endtask

    task automatic drain_reports();
        item_valid <= 1'b0;
        while (report_q.size() != 0)
            @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (hold_req && hold_count < HOLD_CYCLES)
        begin
            hold_count   <= hold_count + 1;
            result_ready <= 1'b0;
        end
        else if (steady)
        begin
            result_ready <= 1'b1;
        end
        else
        begin
            result_ready <= ($urandom_range(99) >= 26);
        end
    end

    always @(posedge clk)
    begin : check_reports
        console_report_t want;
        if (rst_n && result_valid && result_ready)
        begin
            reports_checked++;
            if (report_q.size() == 0)
            begin
                $display("%0t: result with nothing expected: cell %h row %0d col %0d",
                         $time, cell_data, cursor_row, cursor_col);
                fail_count++;
            end
            else
            begin
                want = report_q.pop_front();
                if (cell_data !== want.cell_val)
                begin
                    $display("%0t: cell_data expected %h, actual %h",
                             $time, want.cell_val, cell_data);
                    fail_count++;
                end
                if (cursor_row !== want.row)
                begin
                    $display("%0t: cursor_row expected %0d, actual %0d",
                             $time, want.row, cursor_row);
                    fail_count++;
                end
                if (cursor_col !== want.col)
                begin
                    $display("%0t: cursor_col expected %0d, actual %0d",
                             $time, want.col, cursor_col);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: run timed out with %0d results outstanding",
                     $time, report_q.size());
            $display("tb_text_mode_console_writer_top: errors");
            $finish;
        end
    end

    initial
    begin : stimulus
        console_step_t s;
        int            pick;
        logic [3:0]    fore_sel;
        logic [3:0]    back_sel;

        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = CFG_FORE;
        cfg_data     = 4'h0;
        item_valid   = 1'b0;
        action       = ACT_PUT;
        char_code    = 8'h00;
        row_arg      = 6'sd0;
        col_arg      = 8'sd0;
        scroll_lines = 6'sd0;
        foreach (shadow_cells[k])
            shadow_cells[k] = 16'h0000;
        shadow_row  = 0;
        shadow_col  = 0;
        shadow_fore = FORE_RESET;
        shadow_back = BACK_RESET;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        for (int k = 0; k < DIRECTED_ROWS; k++)
            offer(plan[k]);

        for (int p = 0; p < PHASES; p++)
        begin
            drain_reports();
            case (p)
                0: begin fore_sel = 4'h0; back_sel = 4'h0; end
                1: begin fore_sel = 4'hF; back_sel = 4'hF; end
                2: begin fore_sel = 4'hA; back_sel = 4'h5; end
                3: begin fore_sel = 4'h5; back_sel = 4'hA; end
                default:
                begin
                    fore_sel = 4'($urandom);
                    back_sel = 4'($urandom);
                end
            endcase
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_FORE;
            cfg_data  <= fore_sel;
            @(negedge clk);
            cfg_index <= CFG_BACK;
            cfg_data  <= back_sel;
            @(negedge clk);
            cfg_wr_en <= 1'b0;
            shadow_fore = fore_sel;
            shadow_back = back_sel;

            // phase 2 stalls the receiver while items keep coming;
            // phase 3 runs with no idling on either side
            if (p == 2)
                hold_req <= 1'b1;
            steady <= (p == 3);

            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                s.act      = ACT_PUT;
                s.chr      = 8'($urandom_range(255));
                s.ra       = 6'($urandom);
                s.ca       = 8'($urandom);
                s.sl       = 6'($urandom);
                s.typed    = 1'b0;
                s.cell_val = 16'h0000;
                s.row      = 5'd0;
                s.col      = 7'd0;
                pick = $urandom_range(99);
                if (pick < 48)
                begin
                    if ($urandom_range(99) < 6)
                        s.chr = NEWLINE_CODE;
                end
                else if (pick < 60)
                begin
                    s.act = ACT_SET;
                    if ($urandom_range(9) < 7)
                    begin
                        s.ra = 6'($urandom_range(ROWS - 1));
                        s.ca = 8'($urandom_range(COLS - 1));
                    end
                end
                else if (pick < 70)
                begin
                    s.act = ACT_MOVE;
                    if ($urandom_range(9) < 7)
                    begin
                        s.ra = 6'($urandom_range(6) - 3);
                        s.ca = 8'($urandom_range(20) - 10);
                    end
                end
                else if (pick < 88)
                begin
                    s.act = ACT_READ;
                    // half the time read back the line being written
                    if ($urandom_range(9) < 5)
                    begin
                        s.ra = 6'(shadow_row);
                        s.ca = 8'($urandom_range(COLS - 1));
                    end
                end
                else if (pick < 94)
                begin
                    s.act = ACT_SCROLL;
                    if ($urandom_range(9) < 7)
                        s.sl = 6'($urandom_range(6) - 3);
                end
                else if (pick < 96)
                begin
                    s.act = ACT_CLEAR;
                end
                else
                begin
                    s.act = $urandom_range(1) ? ACT_SPARE7 : ACT_SPARE6;
                end
                offer(s);
            end
        end

        drain_reports();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("summary: %0d put, %0d set, %0d move, %0d scroll, %0d clear, %0d read, %0d spare",
                 act_count[ACT_PUT], act_count[ACT_SET], act_count[ACT_MOVE],
                 act_count[ACT_SCROLL], act_count[ACT_CLEAR], act_count[ACT_READ],
                 act_count[ACT_SPARE6] + act_count[ACT_SPARE7]);
        $display("summary: %0d results compared over %0d color settings, %0d mismatches",
                 reports_checked, PHASES + 1, fail_count);
        if (fail_count == 0)
            $display("tb_text_mode_console_writer_top: clean");
        else
            $display("tb_text_mode_console_writer_top: errors");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/tmcw_pkg.sv
rtl/core/tmcw_screen_ram.sv
rtl/core/tmcw_sweep.sv
rtl/core/text_mode_console_writer_top.sv
tb/tb_text_mode_console_writer_top.sv
